// ===== rtl/core/spi_gpio_expander_regs_assert.svh =====
// Assertion macros shared by the expander modules.
// Each use expects signals named clk and rst_n in the enclosing module.
`ifndef SPI_GPIO_EXPANDER_REGS_ASSERT_SVH
`define SPI_GPIO_EXPANDER_REGS_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SGE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SGE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sge_pkg.sv =====
package sge_pkg;

  // Register file geometry: port A bank then port B bank
  localparam int REGS_PER_BANK = 16;
  localparam int REG_FILE_SIZE = 2 * REGS_PER_BANK;
  localparam int OFF_W         = $clog2(REGS_PER_BANK);
  localparam int REG_IDX_W     = $clog2(REG_FILE_SIZE);

  // Offsets within one bank
  localparam logic [OFF_W-1:0] OFF_IODIR = OFF_W'(4'h0);
  localparam logic [OFF_W-1:0] OFF_IOCON = OFF_W'(4'h5);
  localparam logic [OFF_W-1:0] OFF_GPIO  = OFF_W'(4'h9);
  localparam logic [OFF_W-1:0] OFF_OLAT  = OFF_W'(4'hA);

  // Absolute indexes of the registers the logic touches directly
  localparam logic [REG_IDX_W-1:0] IDX_IODIR_A = {1'b0, OFF_IODIR};
  localparam logic [REG_IDX_W-1:0] IDX_IOCON_A = {1'b0, OFF_IOCON};
  localparam logic [REG_IDX_W-1:0] IDX_GPIO_A  = {1'b0, OFF_GPIO};
  localparam logic [REG_IDX_W-1:0] IDX_OLAT_A  = {1'b0, OFF_OLAT};
  localparam logic [REG_IDX_W-1:0] IDX_IODIR_B = {1'b1, OFF_IODIR};
  localparam logic [REG_IDX_W-1:0] IDX_GPIO_B  = {1'b1, OFF_GPIO};
  localparam logic [REG_IDX_W-1:0] IDX_OLAT_B  = {1'b1, OFF_OLAT};

  // IOCON control bits
  localparam int IOCON_BANK_BIT  = 7;
  localparam int IOCON_SEQOP_BIT = 5;

  // Reset values
  localparam logic [7:0] IODIR_RST  = 8'hFF;
  localparam logic [7:0] GPIO_A_RST = 8'h06;
  localparam logic [7:0] IDLE_REPLY = 8'hFF;

  // Input item kinds
  localparam logic [1:0] KIND_SPI = 2'd0;
  localparam logic [1:0] KIND_CS  = 2'd1;
  localparam logic [1:0] KIND_PIN = 2'd2;

  // Queue between front and back; depth must be a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_CMD  = 2'd0,
    PH_ADDR = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  // Classified operation handed to the back end
  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_SPI_NOP = 3'd1,
    OP_ADDR    = 3'd2,
    OP_READ    = 3'd3,
    OP_WRITE   = 3'd4,
    OP_PIN     = 3'd5
  } op_kind_t;

  typedef struct packed {
    op_kind_t   op;
    logic [7:0] data_byte;
    logic [3:0] pin_index;
    logic       pin_level;
  } sge_op_t;

  typedef struct packed {
    logic       reply_valid;
    logic [7:0] miso_byte;
    logic       drive_bank;
    logic [7:0] drive_changed;
    logic [7:0] drive_levels;
  } sge_res_t;

endpackage

// ===== rtl/core/sge_if.sv =====
// Request channel into the expander
interface sge_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [3:0] pin_index;
  logic       pin_level;

  modport source (output valid, kind, data_byte, pin_index, pin_level, input ready);
  modport sink   (input valid, kind, data_byte, pin_index, pin_level, output ready);
endinterface

// Result channel out of the expander
interface sge_out_if;
  logic       valid;
  logic       ready;
  logic       reply_valid;
  logic [7:0] miso_byte;
  logic       drive_bank;
  logic [7:0] drive_changed;
  logic [7:0] drive_levels;

  modport source (output valid, reply_valid, miso_byte, drive_bank, drive_changed,
                  drive_levels, input ready);
  modport sink   (input valid, reply_valid, miso_byte, drive_bank, drive_changed,
                  drive_levels, output ready);
endinterface

// ===== rtl/core/sge_front.sv =====
module sge_front
  import sge_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  sge_in_if.sink  in_ch,
  input  logic    full,
  output logic    push,
  output sge_op_t push_op
);

  phase_t phase_r, phase_nxt;
  logic   cmd_rd_r, cmd_rd_nxt;

  // Take a request whenever the queue has room
  assign in_ch.ready = !full;
  assign push        = in_ch.valid && !full;

  // Hold frame phase and the read flag of the command byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_CMD;
      cmd_rd_r <= 1'b0;
    end else if (push) begin
      phase_r  <= phase_nxt;
      cmd_rd_r <= cmd_rd_nxt;
    end
  end

  // Classify the request and advance the frame phase
  always_comb begin
    phase_nxt         = phase_r;
    cmd_rd_nxt        = cmd_rd_r;
    push_op.op        = OP_NONE;
    push_op.data_byte = in_ch.data_byte;
    push_op.pin_index = in_ch.pin_index;
    push_op.pin_level = in_ch.pin_level;
    case (in_ch.kind)
      KIND_SPI: begin
        unique case (phase_r)
          PH_CMD: begin
            cmd_rd_nxt = in_ch.data_byte[0];
            phase_nxt  = PH_ADDR;
            push_op.op = OP_SPI_NOP;
          end
          PH_ADDR: begin
            phase_nxt  = PH_DATA;
            push_op.op = OP_ADDR;
          end
          PH_DATA: begin
            push_op.op = cmd_rd_r ? OP_READ : OP_WRITE;
          end
          default: begin
            push_op.op = OP_SPI_NOP;
          end
        endcase
      end
      KIND_CS: begin
        phase_nxt = PH_CMD;
      end
      KIND_PIN: begin
        push_op.op = OP_PIN;
      end
      default: begin
        push_op.op = OP_NONE;
      end
    endcase
  end

endmodule

// ===== rtl/core/sge_queue.sv =====
`include "spi_gpio_expander_regs_assert.svh"

module sge_queue
  import sge_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  sge_op_t push_op,
  input  logic    pop,
  output sge_op_t pop_op,
  output logic    full,
  output logic    empty
);

  localparam logic [QCNT_W-1:0] QUEUE_FULL = QCNT_W'(QUEUE_DEPTH);

  sge_op_t           q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full   = (cnt_r == QUEUE_FULL);
  assign empty  = (cnt_r == '0);
  assign pop_op = q_r[rd_ptr_r];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= push_op;
  end

  `SGE_ASSERT_IMP(a_no_push_when_full, push, !full, "push into a full queue")
  `SGE_ASSERT_IMP(a_no_pop_when_empty, pop, !empty, "pop from an empty queue")
  `SGE_ASSERT_IMP(a_count_bound, 1'b1, cnt_r <= QUEUE_FULL, "queue count overflow")

endmodule

// ===== rtl/core/sge_back.sv =====
`include "spi_gpio_expander_regs_assert.svh"

module sge_back
  import sge_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     empty,
  input  sge_op_t  pop_op,
  output logic     pop,
  sge_out_if.source out_ch
);

  logic [7:0]           rf_r [REG_FILE_SIZE];
  logic [7:0]           rf_nxt [REG_FILE_SIZE];
  logic [7:0]           ptr_r, ptr_nxt;
  logic                 out_valid_r;
  sge_res_t             out_r, res_nxt;

  logic [7:0]           iocon;
  logic [7:0]           map_addr;
  logic                 in_range;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_bank;
  logic [7:0]           dir, old_olat, new_olat;
  logic [7:0]           pin_dir;
  logic                 seqop;

  // Take the next queued request when the output register is free or draining
  assign pop = !empty && (!out_valid_r || out_ch.ready);

  // Map the frame address into the banked layout
  always_comb begin
    iocon = rf_r[IDX_IOCON_A];
    if (iocon[IOCON_BANK_BIT]) map_addr = ptr_r;
    else map_addr = {1'b0, ptr_r[7:1]} | {3'b000, ptr_r[0], 4'b0000};
    in_range = (map_addr[7:REG_IDX_W] == '0);
    idx      = map_addr[REG_IDX_W-1:0];
    wr_bank  = idx[OFF_W];
    dir      = wr_bank ? rf_r[IDX_IODIR_B] : rf_r[IDX_IODIR_A];
    old_olat = wr_bank ? rf_r[IDX_OLAT_B] : rf_r[IDX_OLAT_A];
    new_olat = (pop_op.data_byte & ~dir) | (old_olat & dir);
    pin_dir  = pop_op.pin_index[3] ? rf_r[IDX_IODIR_B] : rf_r[IDX_IODIR_A];
  end

  // Execute the request against the register file
  always_comb begin
    rf_nxt  = rf_r;
    ptr_nxt = ptr_r;
    seqop   = iocon[IOCON_SEQOP_BIT];
    res_nxt = '0;
    case (pop_op.op)
      OP_SPI_NOP: begin
        res_nxt.reply_valid = 1'b1;
        res_nxt.miso_byte   = IDLE_REPLY;
      end
      OP_ADDR: begin
        res_nxt.reply_valid = 1'b1;
        res_nxt.miso_byte   = IDLE_REPLY;
        ptr_nxt             = pop_op.data_byte;
      end
      OP_READ: begin
        res_nxt.reply_valid = 1'b1;
        res_nxt.miso_byte   = in_range ? rf_r[idx] : IDLE_REPLY;
        if (!seqop) ptr_nxt = ptr_r + 8'd1;
      end
      OP_WRITE: begin
        res_nxt.reply_valid = 1'b1;
        res_nxt.miso_byte   = IDLE_REPLY;
        if (in_range) begin
          if (idx[OFF_W-1:0] == OFF_GPIO || idx[OFF_W-1:0] == OFF_OLAT) begin
            // GPIO and OLAT both land in the output latch of that port
            if (wr_bank) rf_nxt[IDX_OLAT_B] = new_olat;
            else rf_nxt[IDX_OLAT_A] = new_olat;
            res_nxt.drive_bank    = wr_bank;
            res_nxt.drive_changed = (old_olat ^ pop_op.data_byte) & ~dir;
            res_nxt.drive_levels  = new_olat;
          end else begin
            rf_nxt[idx] = pop_op.data_byte;
            if (idx == IDX_IOCON_A) seqop = pop_op.data_byte[IOCON_SEQOP_BIT];
          end
        end
        if (!seqop) ptr_nxt = ptr_r + 8'd1;
      end
      OP_PIN: begin
        // Only input pins follow the external level
        if (pin_dir[pop_op.pin_index[2:0]]) begin
          if (pop_op.pin_index[3])
            rf_nxt[IDX_GPIO_B][pop_op.pin_index[2:0]] = pop_op.pin_level;
          else
            rf_nxt[IDX_GPIO_A][pop_op.pin_index[2:0]] = pop_op.pin_level;
        end
      end
      default: begin
        res_nxt = '0;
      end
    endcase
  end

  // Update register file and pointer on each executed request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_FILE_SIZE; i++) begin
        if (REG_IDX_W'(i) == IDX_IODIR_A || REG_IDX_W'(i) == IDX_IODIR_B)
          rf_r[i] <= IODIR_RST;
        else if (REG_IDX_W'(i) == IDX_GPIO_A)
          rf_r[i] <= GPIO_A_RST;
        else
          rf_r[i] <= 8'h00;
      end
      ptr_r <= 8'h00;
    end else if (pop) begin
      rf_r  <= rf_nxt;
      ptr_r <= ptr_nxt;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_r <= res_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.reply_valid   = out_r.reply_valid;
  assign out_ch.miso_byte     = out_r.miso_byte;
  assign out_ch.drive_bank    = out_r.drive_bank;
  assign out_ch.drive_changed = out_r.drive_changed;
  assign out_ch.drive_levels  = out_r.drive_levels;

  `SGE_ASSERT_IMP(a_quiet_miso_off_spi, out_valid_r && !out_r.reply_valid,
                  out_r.miso_byte == 8'h00, "reply byte on a non-spi result")
  `SGE_ASSERT_IMP(a_drive_only_on_spi, out_valid_r && out_r.drive_changed != 8'h00,
                  out_r.reply_valid, "drive change on a non-spi result")
  `SGE_ASSERT_NXT(a_addr_loads_ptr, pop && pop_op.op == OP_ADDR,
                  ptr_r == $past(pop_op.data_byte), "address byte not loaded")
  `SGE_ASSERT_NXT(a_pin_keeps_dir, pop && pop_op.op == OP_PIN,
                  $stable(rf_r[IDX_IODIR_A]) && $stable(rf_r[IDX_IODIR_B]),
                  "pin event changed a direction register")

endmodule

// ===== rtl/core/spi_gpio_expander_regs.sv =====
// Register file of a 16-pin SPI GPIO expander.
// in_ch carries one request per handshake: an SPI byte, a chip-select
// release, or an external pin level change. out_ch returns exactly one
// result per request, in order: the reply byte for SPI bytes (read data in
// the data phase of a read frame, else 0xFF) and, for writes to GPIO or
// OLAT, the port, the mask of output pins that changed and the new latch.
// A front stage classifies each request by frame phase and pushes it into a
// two-entry queue; a back stage executes it on the register file and loads
// the output register, which drives out_ch.valid. Throughput is one request
// per cycle while out_ch is ready, limited by the single register-file
// update per cycle in the back stage.
// If out_ch stalls, the result holds, the back stage stops, and in_ch keeps
// accepting until the queue fills (two requests beyond the held result).
// Synchronous reset returns the frame to the command phase, clears the
// pointer and queue, and loads the register file: all zero except both
// direction registers 0xFF and port A GPIO 0x06.
module spi_gpio_expander_regs
  import sge_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  sge_in_if.sink    in_ch,
  sge_out_if.source out_ch
);

  logic    push, pop, full, empty;
  sge_op_t push_op, pop_op;

  sge_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .full    (full),
    .push    (push),
    .push_op (push_op)
  );

  sge_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .pop_op  (pop_op),
    .full    (full),
    .empty   (empty)
  );

  sge_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop_op (pop_op),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// ===== sim/spi_gpio_expander_regs_tb.sv =====
`timescale 1ns / 1ps

module spi_gpio_expander_regs_tb;
  import sge_pkg::*;

  localparam int          TOTAL_REQUESTS = 1650;
  localparam int          HANG_LIMIT     = 2000;
  localparam int          CMD_READ_BIT   = 0;
  localparam logic [1:0]  KIND_NONE      = 2'd3;
  localparam logic [7:0]  CMD_WRITE      = 8'h40;
  localparam logic [7:0]  CMD_READ       = 8'h41;

  // Register-file model plus the queue of replies it predicts
  class expander_scoreboard;
    phase_t      phase;
    logic [7:0]  cmd_byte;
    logic [7:0]  reg_ptr;
    logic [7:0]  regs [REG_FILE_SIZE];
    sge_res_t    expected_replies[$];
    int unsigned mismatches;

    function new();
      phase = PH_CMD;
      cmd_byte = '0;
      reg_ptr = '0;
      foreach (regs[i]) regs[i] = '0;
      regs[IDX_IODIR_A] = IODIR_RST;
      regs[IDX_IODIR_B] = IODIR_RST;
      regs[IDX_GPIO_A] = GPIO_A_RST;
      mismatches = 0;
    endfunction

    // Apply one accepted request and queue the reply it should produce
    function void note_request(logic [1:0] kind, logic [7:0] data, logic [3:0] pin,
                               logic level);
      sge_res_t    res;
      int unsigned idx;
      int unsigned base;
      logic [7:0]  dir;
      logic [7:0]  old_latch;
      logic [7:0]  new_latch;
      logic [7:0]  bit_sel;
      res = '0;
      case (kind)
        KIND_SPI: begin
          res.reply_valid = 1'b1;
          res.miso_byte = IDLE_REPLY;
          case (phase)
            PH_CMD: begin
              cmd_byte = data;
              phase = PH_ADDR;
            end
            PH_ADDR: begin
              reg_ptr = data;
              phase = PH_DATA;
            end
            PH_DATA: begin
              // interleaved layout carries the port in bit 0
              if (regs[IDX_IOCON_A][IOCON_BANK_BIT]) idx = reg_ptr;
              else idx = (int'(reg_ptr) >> 1) | (int'(reg_ptr[0]) << 4);
              if (idx < REG_FILE_SIZE) begin
                if (cmd_byte[CMD_READ_BIT]) begin
                  res.miso_byte = regs[idx];
                end else if (idx % REGS_PER_BANK == OFF_GPIO ||
                             idx % REGS_PER_BANK == OFF_OLAT) begin
                  // only output pins take the new level
                  base = idx - idx % REGS_PER_BANK;
                  dir = regs[base + OFF_IODIR];
                  old_latch = regs[base + OFF_OLAT];
                  new_latch = (data & ~dir) | (old_latch & dir);
                  regs[base + OFF_OLAT] = new_latch;
                  res.drive_bank = (base != 0);
                  res.drive_changed = (old_latch ^ data) & ~dir;
                  res.drive_levels = new_latch;
                end else begin
                  regs[idx] = data;
                end
              end
              if (!regs[IDX_IOCON_A][IOCON_SEQOP_BIT]) reg_ptr = reg_ptr + 8'd1;
            end
            default: ;
          endcase
        end
        KIND_CS: phase = PH_CMD;
        KIND_PIN: begin
          // input pins follow the external level
          base = pin[3] ? REGS_PER_BANK : 0;
          bit_sel = 8'd1 << pin[2:0];
          if ((regs[base + OFF_IODIR] & bit_sel) != 8'd0) begin
            if (level) regs[base + OFF_GPIO] = regs[base + OFF_GPIO] | bit_sel;
            else regs[base + OFF_GPIO] = regs[base + OFF_GPIO] & ~bit_sel;
          end
        end
        default: ;
      endcase
      expected_replies.push_back(res);
    endfunction

    // Compare one result with the oldest predicted reply
    function void check_result(sge_res_t got);
      sge_res_t want;
      if (expected_replies.size() == 0) begin
        $error("result with no request pending");
        mismatches++;
        return;
      end
      want = expected_replies.pop_front();
      if (got.reply_valid !== want.reply_valid) begin
        $error("reply_valid: expected %0h, actual %0h", want.reply_valid, got.reply_valid);
        mismatches++;
      end
      if (got.miso_byte !== want.miso_byte) begin
        $error("miso_byte: expected %0h, actual %0h", want.miso_byte, got.miso_byte);
        mismatches++;
      end
      if (got.drive_bank !== want.drive_bank) begin
        $error("drive_bank: expected %0h, actual %0h", want.drive_bank, got.drive_bank);
        mismatches++;
      end
      if (got.drive_changed !== want.drive_changed) begin
        $error("drive_changed: expected %0h, actual %0h", want.drive_changed,
               got.drive_changed);
        mismatches++;
      end
      if (got.drive_levels !== want.drive_levels) begin
        $error("drive_levels: expected %0h, actual %0h", want.drive_levels,
               got.drive_levels);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sge_in_if  in_ch ();
  sge_out_if out_ch ();

  spi_gpio_expander_regs dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  expander_scoreboard sb;
  int unsigned        requests_sent = 0;
  int unsigned        quiet_cycles = 0;
  bit                 src_calm = 1'b0;
  bit                 sink_calm = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones, none while calm
  function automatic int unsigned idle_cycles(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 8'h00;
    if (r < 16) return 8'hFF;
    return 8'($urandom);
  endfunction

  // Frame address of a register in either layout
  function automatic logic [7:0] reg_addr(bit banked, bit port, logic [3:0] off);
    return banked ? {3'b000, port, off} : {3'b000, off, port};
  endfunction

  function automatic logic [7:0] pick_addr();
    int unsigned r;
    logic [3:0]  off;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      case ($urandom_range(0, 3))
        0: off = OFF_IODIR;
        1: off = OFF_GPIO;
        2: off = OFF_OLAT;
        default: off = 4'($urandom);
      endcase
      return reg_addr(1'($urandom), 1'($urandom), off);
    end
    if (r < 80) return 8'($urandom_range(0, 63));
    return 8'($urandom);
  endfunction

  // Present one request and hold it until accepted
  task automatic send_request(input logic [1:0] kind, input logic [7:0] data,
                              input logic [3:0] pin, input logic level);
    int unsigned gap;
    gap = idle_cycles(src_calm);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.data_byte <= data;
    in_ch.pin_index <= pin;
    in_ch.pin_level <= level;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (kind != KIND_NONE) requests_sent++;
  endtask

  task automatic spi_byte(input logic [7:0] data);
    send_request(KIND_SPI, data, 4'($urandom), 1'($urandom));
  endtask

  task automatic cs_release();
    send_request(KIND_CS, 8'($urandom), 4'($urandom), 1'($urandom));
  endtask

  task automatic pin_event(input logic [3:0] pin, input logic level);
    send_request(KIND_PIN, 8'($urandom), pin, level);
  endtask

  task automatic run_frame(input logic [7:0] cmd, input logic [7:0] addr,
                           input logic [7:0] payload[$]);
    cs_release();
    spi_byte(cmd);
    spi_byte(addr);
    foreach (payload[i]) spi_byte(payload[i]);
  endtask

  // Check results, predict requests and watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        sb.check_result(sge_res_t'({out_ch.reply_valid, out_ch.miso_byte, out_ch.drive_bank,
                                    out_ch.drive_changed, out_ch.drive_levels}));
      if (in_ch.valid && in_ch.ready)
        sb.note_request(in_ch.kind, in_ch.data_byte, in_ch.pin_index, in_ch.pin_level);
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles == HANG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Result side: random stalls, accept one result per ready window
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = idle_cycles(sink_calm);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      if ($urandom_range(0, 49) == 0) sink_calm = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    logic [7:0]  bytes_q[$];
    int unsigned r;
    int unsigned n;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_SPI;
    in_ch.data_byte = '0;
    in_ch.pin_index = '0;
    in_ch.pin_level = 1'b0;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values of GPIO in both ports, interleaved layout
    bytes_q = {8'h00, 8'hFF};
    run_frame(CMD_READ, reg_addr(1'b0, 1'b0, OFF_GPIO), bytes_q);
    // Port A all outputs, port B upper nibble inputs
    bytes_q = {8'h00, 8'hF0};
    run_frame(CMD_WRITE, reg_addr(1'b0, 1'b0, OFF_IODIR), bytes_q);
    // Latch A then latch B; B masks its input pins
    bytes_q = {8'hFF, 8'hA5};
    run_frame(CMD_WRITE, reg_addr(1'b0, 1'b0, OFF_OLAT), bytes_q);
    // Pin events on an input pin and on an output pin
    pin_event(4'd15, 1'b1);
    pin_event(4'd0, 1'b1);
    send_request(KIND_NONE, 8'hFF, 4'd15, 1'b1);
    // Switch to banked layout with the pointer held
    bytes_q = {8'hA0};
    run_frame(CMD_WRITE, reg_addr(1'b0, 1'b0, OFF_IOCON), bytes_q);
    // Read past the register file
    bytes_q = {8'h00, 8'h00};
    run_frame(CMD_READ, 8'hFF, bytes_q);
    // Back to interleaved layout with auto-increment
    bytes_q = {8'h00};
    run_frame(CMD_WRITE, reg_addr(1'b1, 1'b0, OFF_IOCON), bytes_q);

    while (requests_sent < TOTAL_REQUESTS) begin
      if ($urandom_range(0, 29) == 0) src_calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 70) begin
        // well-formed frame with random content
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        bytes_q = {};
        repeat (n) bytes_q.push_back(pick_byte());
        run_frame(8'($urandom), pick_addr(), bytes_q);
      end else if (r < 80) begin
        repeat ($urandom_range(1, 4)) pin_event(4'($urandom), 1'($urandom));
      end else if (r < 88) begin
        // stray bytes, or a frame cut after its command
        if ($urandom_range(0, 1) == 0) begin
          repeat ($urandom_range(1, 3)) spi_byte(pick_byte());
        end else begin
          cs_release();
          spi_byte(8'($urandom));
        end
      end else if (r < 92) begin
        send_request(KIND_NONE, 8'($urandom), 4'($urandom), 1'($urandom));
      end else begin
        cs_release();
      end
    end
    in_ch.valid <= 1'b0;

    // Drain, then watch a few more cycles for stray results
    while (sb.expected_replies.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_replies.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/sge_pkg.sv
rtl/core/sge_if.sv
rtl/core/sge_front.sv
rtl/core/sge_queue.sv
rtl/core/sge_back.sv
rtl/core/spi_gpio_expander_regs.sv
sim/spi_gpio_expander_regs_tb.sv
